[src/tcw_pkg.sv]
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int IDX_W  = $clog2(CELL_COUNT);
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // control bytes
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BLANK,
    ST_CLEAR,
    ST_READ,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [LOC_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;
  } result_t;

endpackage

[src/text_console_character_writer_top.sv]
// channel | handshake           | payload
// --------+---------------------+----------------------------------------------------
// in      | in_valid_i/ready_o  | action_i, char_code_i, back_color_i, fore_color_i,
//         |                     | read_index_i
// out     | out_valid_o/ready_i | cursor_pos_o, cell_value_o
//
// a put of a control byte or glyph passes ST_PUT, then ST_DONE hands its result to the
// result register, and the block returns to ST_IDLE for the next accept
// a put that scrolls copies the screen up one row through the single cell ram
// port pair, a read state and a write state per cell, then blanks the last row
// clear sweeps every cell once; a read passes ST_READ, then ST_RD_WAIT since the ram
// read is registered, then ST_DONE, before its result reaches the result register
// after reset the block blanks the whole store, one cell per cycle, before it raises
// in_ready_o; one item is in flight at a time
// the result register lets the sequencer take the next item while out_ready_i is low;
// that item's result then waits in the sequencer until the register drains
module text_console_character_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  back_color_i,
  input  logic [3:0]  fore_color_i,
  input  logic [10:0] read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_pos_o,
  output logic [15:0] cell_value_o
);
  import tcw_pkg::*;

  mem_req_t          req;
  logic [CELL_W-1:0] rdata;
  result_t           res;

  // result register
  logic              out_valid_q;
  logic [LOC_W-1:0]  loc_q;
  logic [CELL_W-1:0] cell_q;
  logic              out_free;

  // the sequencer may hand over a new result when the register is empty or drains this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer: cursor, control byte decode, scroll / clear sweeps
  tcw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .back_color_i (back_color_i),
    .fore_color_i (fore_color_i),
    .read_index_i (read_index_i),
    .out_free_i   (out_free),
    .req_o        (req),
    .rdata_i      (rdata),
    .res_o        (res)
  );

  // screen store, one write and one registered read per cycle
  tcw_cell_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      loc_q  <= res.cursor_pos;
      cell_q <= res.cell_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = loc_q;
  assign cell_value_o = cell_q;

endmodule

[src/tcw_cell_ram.sv]
module tcw_cell_ram (
  input  logic                          clk_i,
  input  tcw_pkg::mem_req_t             req_i,
  output logic [tcw_pkg::CELL_W-1:0]    rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[src/tcw_ctrl.sv]
module tcw_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [7:0]                  char_code_i,
  input  logic [3:0]                  back_color_i,
  input  logic [3:0]                  fore_color_i,
  input  logic [10:0]                 read_index_i,
  input  logic                        out_free_i,
  output tcw_pkg::mem_req_t           req_o,
  input  logic [tcw_pkg::CELL_W-1:0]  rdata_i,
  output tcw_pkg::result_t            res_o
);
  import tcw_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(CELL_COUNT - 1);
  localparam logic [IDX_W-1:0] COPY_LAST = IDX_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [IDX_W-1:0] IDX_COLS  = IDX_W'(COLUMNS);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic [COL_W:0]   COL_ONE   = (COL_W+1)'(1);
  localparam logic [ROW_W:0]   ROW_ONE   = (ROW_W+1)'(1);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [7:0]        ch_q, ch_d;
  logic [7:0]        attr_q, attr_d;
  logic [10:0]       ridx_q, ridx_d;
  logic [CELL_W-1:0] cell_q, cell_d;

  logic [COL_W:0]    col_n;
  logic [ROW_W:0]    row_n;
  logic              glyph;
  logic [IDX_W-1:0]  pos;

  // cursor step for a put item
  always_comb begin
    col_n = {1'b0, col_q};
    row_n = {1'b0, row_q};
    glyph = 1'b0;
    if (ch_q == CH_BS && col_q != '0) begin
      col_n = col_n - COL_ONE;
    end else if (ch_q == CH_TAB) begin
      col_n = (col_n + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
    end else if (ch_q == CH_CR) begin
      col_n = '0;
    end else if (ch_q == CH_LF) begin
      col_n = '0;
      row_n = row_n + ROW_ONE;
    end else begin
      glyph = 1'b1;
      col_n = col_n + COL_ONE;
    end
    if (col_n >= (COL_W+1)'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + ROW_ONE;
    end
  end

  assign pos = IDX_W'(int'(row_q) * COLUMNS + int'(col_q));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    col_d      = col_q;
    row_d      = row_q;
    ch_d       = ch_q;
    attr_d     = attr_q;
    ridx_d     = ridx_q;
    cell_d     = cell_q;
    req_o      = '0;
    in_ready_o = 1'b0;
    res_o      = '0;
    res_o.cursor_pos = LOC_W'(int'(row_q) * COLUMNS + int'(col_q));
    res_o.cell_value = cell_q;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        req_o.wdata = BLANK_CELL;
        idx_d       = idx_q + IDX_ONE;
        if (idx_q == IDX_LAST) begin
          idx_d = '0;
          col_d = '0;
          row_d = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d   = char_code_i;
          attr_d = {back_color_i, fore_color_i};
          ridx_d = read_index_i;
          cell_d = '0;
          idx_d  = '0;
          case (action_i)
            ACT_PUT:   state_d = ST_PUT;
            ACT_CLEAR: state_d = ST_CLEAR;
            ACT_READ:  state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        req_o.we    = glyph;
        req_o.waddr = pos;
        req_o.wdata = {attr_q, ch_q};
        col_d       = col_n[COL_W-1:0];
        if (row_n >= (ROW_W+1)'(ROWS)) begin
          row_d   = ROW_W'(ROWS - 1);
          state_d = ST_SCR_RD;
        end else begin
          row_d   = row_n[ROW_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_SCR_RD: begin
        req_o.raddr = idx_q + IDX_COLS;
        state_d     = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        req_o.wdata = rdata_i;
        idx_d       = idx_q + IDX_ONE;
        state_d     = (idx_q == COPY_LAST) ? ST_BLANK : ST_SCR_RD;
      end
      ST_BLANK: begin
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        req_o.wdata = BLANK_CELL;
        idx_d       = idx_q + IDX_ONE;
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        req_o.raddr = IDX_W'(ridx_q);
        state_d     = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (32'(ridx_q) < 32'(CELL_COUNT)) begin
          cell_d = rdata_i;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    attr_q <= attr_d;
    ridx_q <= ridx_d;
    cell_q <= cell_d;
  end

endmodule
